FILE: rtl/cltok_pkg.sv
// ----------------------------------------------------------------------------
// cltok_pkg
// shared types and character codes for the command line tokenizer
// ----------------------------------------------------------------------------
package cltok_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_LIST = 2'd2
  } kind_e;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned OFF_W = 9;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    logic             ovf;
    logic             last;
  } res_t;

endpackage

FILE: rtl/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// splits a command line, one byte per request, into token bytes, token ends
// and an end-of-list mark, with quoting, escapes and overflow saturation
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_byte_i, end_of_line_i
//  out     | source    | out_valid_o/out_stall_i | kind_o, out_byte_o, token_index_o,
//          |           |                      | char_offset_o, overflow_o, last_o
//
// one request is taken per cycle while it yields at most one result and out_stall_i
// is low; a request that yields n results (up to three at end of line) holds
// in_stall_o while the three-entry result queue drains one result per cycle
// the queue is the only buffering; a request is taken in the cycle the queue
// empties, so results of consecutive requests leave back to back
// out_stall_i holds the queue head and, once it is the last entry, the input
// rst_ni clears line state and empties the queue at once; no clearing pass
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int unsigned LINE_BYTES  = 256,
  parameter int unsigned TOKEN_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_line_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cltok_pkg::kind_e  kind_o,
  output logic [7:0]        out_byte_o,
  output logic [5:0]        token_index_o,
  output logic [8:0]        char_offset_o,
  output logic              overflow_o,
  output logic              last_o
);
  import cltok_pkg::*;

  // token count holds up to TOKEN_SLOTS-1, byte counts up to LINE_BYTES
  localparam int unsigned CW = (TOKEN_SLOTS > 2) ? $clog2(TOKEN_SLOTS) : 1;
  localparam int unsigned BW = $clog2(LINE_BYTES + 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(TOKEN_SLOTS - 1);
  localparam logic [BW:0]   BYTE_MAX = (BW + 1)'(LINE_BYTES);

  // line state
  logic          quote_q, quote_d;
  logic          esc_q, esc_d;
  logic [BW-1:0] len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [BW-1:0] used_q, used_d;
  logic          ovf_q, ovf_d;

  // result queue, head at entry 0
  res_t       ent_q [3];
  res_t       ent_d [3];
  logic [1:0] qcnt_q, qcnt_d;

  logic in_take, out_take;

  // build one result with fixed-width index and offset
  function automatic res_t mk_res(kind_e k, logic [7:0] b, logic [CW-1:0] idx,
                                  logic [BW-1:0] off);
    res_t r;
    logic [CW+IDX_W-1:0] idx_w;
    logic [BW+OFF_W-1:0] off_w;
    idx_w  = {{IDX_W{1'b0}}, idx};
    off_w  = {{OFF_W{1'b0}}, off};
    r.kind = k;
    r.data = b;
    r.idx  = idx_w[IDX_W-1:0];
    r.off  = off_w[OFF_W-1:0];
    r.ovf  = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  assign out_valid_o = (qcnt_q != 2'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  // take a request when the queue is empty or empties in this cycle
  assign in_stall_o  = !((qcnt_q == 2'd0) || ((qcnt_q == 2'd1) && out_take));
  assign in_take     = in_valid_i && !in_stall_o;

  assign kind_o        = ent_q[0].kind;
  assign out_byte_o    = ent_q[0].data;
  assign token_index_o = ent_q[0].idx;
  assign char_offset_o = ent_q[0].off;
  assign overflow_o    = ent_q[0].ovf;
  assign last_o        = ent_q[0].last;

  logic [7:0]    ch;
  logic          act_byte, act_end;
  logic          byte_ok, end_ok, end2_ok;
  logic          va, vb;
  res_t          ra, rb, rc;
  logic [BW-1:0] len1, used1, used2;
  logic [CW-1:0] cnt1, cnt2;
  logic          ovf1, ovf2;
  logic          nq, ne;
  res_t          nw [3];
  logic [1:0]    nn;

  always_comb begin
    // decode the byte against quote and escape state
    ch       = in_byte_i;
    act_byte = 1'b0;
    act_end  = 1'b0;
    nq       = quote_q;
    ne       = esc_q;
    priority if (esc_q) begin
      ne       = 1'b0;
      act_byte = 1'b1;
      unique case (in_byte_i)
        CHAR_T:    ch = CHAR_TAB;
        CHAR_R:    ch = CHAR_CR;
        CHAR_N:    ch = CHAR_LF;
        CHAR_ZERO: ch = CHAR_NUL;
        default:   ch = in_byte_i;
      endcase
    end else if (in_byte_i == CHAR_SPACE || in_byte_i == CHAR_LF ||
                 in_byte_i == CHAR_TAB) begin
      if (quote_q) begin
        act_byte = 1'b1;
      end else if (len_q != '0) begin
        act_end = 1'b1;
      end
    end else if (in_byte_i == CHAR_DQUOTE) begin
      nq      = !quote_q;
      act_end = quote_q;
    end else if (in_byte_i == CHAR_BSLASH) begin
      ne = 1'b1;
    end else begin
      act_byte = 1'b1;
    end

    // first action: a token byte or a token end, within both budgets
    byte_ok = (cnt_q < CNT_MAX) && (({1'b0, used_q} + (BW + 1)'(2)) <= BYTE_MAX);
    end_ok  = (cnt_q < CNT_MAX) && (({1'b0, used_q} + (BW + 1)'(1)) <= BYTE_MAX);
    va    = 1'b0;
    ra    = mk_res(KIND_BYTE, ch, cnt_q, len_q);
    len1  = len_q;
    cnt1  = cnt_q;
    used1 = used_q;
    ovf1  = ovf_q;
    if (act_byte) begin
      if (byte_ok) begin
        va    = 1'b1;
        len1  = len_q + BW'(1);
        used1 = used_q + BW'(1);
      end else begin
        ovf1 = 1'b1;
      end
    end else if (act_end) begin
      ra   = mk_res(KIND_END, CHAR_NUL, cnt_q, len_q);
      len1 = '0;
      if (end_ok) begin
        va    = 1'b1;
        cnt1  = cnt_q + CW'(1);
        used1 = used_q + BW'(1);
      end else begin
        ovf1 = 1'b1;
      end
    end

    // end of line: close an open token, then the list mark
    end2_ok = (cnt1 < CNT_MAX) && (({1'b0, used1} + (BW + 1)'(1)) <= BYTE_MAX);
    vb    = 1'b0;
    rb    = mk_res(KIND_END, CHAR_NUL, cnt1, len1);
    cnt2  = cnt1;
    used2 = used1;
    ovf2  = ovf1;
    if (end_of_line_i && len1 != '0) begin
      if (end2_ok) begin
        vb    = 1'b1;
        cnt2  = cnt1 + CW'(1);
        used2 = used1 + BW'(1);
      end else begin
        ovf2 = 1'b1;
      end
    end
    rc = mk_res(KIND_LIST, CHAR_NUL, cnt2, '0);

    // pack results in order, sticky flag and last marker on each
    nw[0] = va ? ra : (vb ? rb : rc);
    nw[1] = va ? (vb ? rb : rc) : rc;
    nw[2] = rc;
    nn    = 2'(va) + 2'(vb) + 2'(end_of_line_i);
    for (int i = 0; i < 3; i++) begin
      nw[i].ovf  = ovf2;
      nw[i].last = (2'(i) == nn - 2'd1);
    end

    // next line state
    quote_d = quote_q;
    esc_d   = esc_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    used_d  = used_q;
    ovf_d   = ovf_q;
    if (in_take) begin
      if (end_of_line_i) begin
        quote_d = 1'b0;
        esc_d   = 1'b0;
        len_d   = '0;
        cnt_d   = '0;
        used_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        quote_d = nq;
        esc_d   = ne;
        len_d   = len1;
        cnt_d   = cnt1;
        used_d  = used1;
        ovf_d   = ovf1;
      end
    end

    // queue: a new request refills it; otherwise pop shifts the head out
    ent_d  = ent_q;
    qcnt_d = qcnt_q;
    if (in_take) begin
      ent_d  = nw;
      qcnt_d = nn;
    end else if (out_take) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      qcnt_d   = qcnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= 1'b0;
      esc_q   <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      used_q  <= '0;
      ovf_q   <= 1'b0;
      qcnt_q  <= 2'd0;
    end else begin
      quote_q <= quote_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      ovf_q   <= ovf_d;
      qcnt_q  <= qcnt_d;
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

FILE: rtl/cltok_checker.sv
// ----------------------------------------------------------------------------
// cltok_checker
// port-level checks for the command line tokenizer
// ----------------------------------------------------------------------------
module cltok_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic [8:0] char_offset_o,
  input logic       last_o
);
  import cltok_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result blocks new requests
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while result queue is held");

  // the list mark closes the request's results
  a_list_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_LIST |-> last_o && char_offset_o == '0)
    else $error("list mark without last or with offset");

  // only token bytes carry data
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> out_byte_o == '0)
    else $error("end result carries a byte");

endmodule

bind command_line_tokenizer cltok_checker u_cltok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .out_byte_o    (out_byte_o),
  .char_offset_o (char_offset_o),
  .last_o        (last_o)
);
